@@ sv/lz77_token_decompressor_defines.svh @@
// assertion macros used by the lz77 token decompressor rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef LZ77_TOKEN_DECOMPRESSOR_DEFINES_SVH
`define LZ77_TOKEN_DECOMPRESSOR_DEFINES_SVH

`ifndef ASSERT_OFF
// labelled concurrent check on an explicit clock and active-low reset
`define LZD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// same check on the block clock and reset
`define LZD_ASSERT(lbl, prop, msg) `LZD_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)
`else
`define LZD_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define LZD_ASSERT(lbl, prop, msg)
`endif

`endif

@@ sv/lzd_pkg.sv @@
// types, constants and helper functions of the lz77 token decompressor
// no dependencies; imported by every module of the block but lzd_ram
`default_nettype none

package lzd_pkg;

    localparam int BYTE_W            = 8;
    localparam int BYTES_PER_RESULT  = 8;
    localparam int OUT_BYTES_W       = BYTE_W * BYTES_PER_RESULT;
    localparam int OUT_COUNT_W       = 4;
    localparam int SLOT_W            = $clog2(BYTES_PER_RESULT);
    localparam int HISTORY_DEPTH_DEF = 8192;

    // produced-byte count saturates at the largest copy distance
    localparam int PRODUCED_W = 14;
    localparam logic [PRODUCED_W-1:0] PRODUCED_MAX = 14'd8192;

    // token fields
    localparam int OFF_HIGH_W = 5;
    localparam int LEN_CODE_W = 3;
    localparam int LIT_LEFT_W = 6;
    localparam int COPY_LEN_W = 9;
    localparam logic [LEN_CODE_W-1:0] LEN_CODE_LITERAL = 3'd0;
    localparam logic [LEN_CODE_W-1:0] LEN_CODE_LONG    = 3'd7;
    localparam logic [COPY_LEN_W-1:0] SHORT_COPY_BASE  = 9'd2;
    localparam logic [COPY_LEN_W-1:0] LONG_COPY_BASE   = 9'd9;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LITERAL,
        PH_OFFSET,
        PH_LENGTH
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_ERR
    } ctrl_state_t;

    typedef struct packed {
        logic [OUT_BYTES_W-1:0] out_bytes;
        logic [OUT_COUNT_W-1:0] out_count;
        logic                   run_last;
        logic                   format_error;
    } result_t;

    // error word: no bytes, closes the run
    function automatic result_t err_result();
        result_t r;
        r.out_bytes    = '0;
        r.out_count    = '0;
        r.run_last     = 1'b1;
        r.format_error = 1'b1;
        return r;
    endfunction

    // one literal byte
    function automatic result_t literal_result(input logic [BYTE_W-1:0] b,
                                               input logic last);
        result_t r;
        r.out_bytes    = OUT_BYTES_W'(b);
        r.out_count    = OUT_COUNT_W'(1);
        r.run_last     = last;
        r.format_error = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/lzd_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/lzd_outbuf.sv @@
// output holding register of the decompressor result channel
// depends on lzd_pkg for the result word type
`default_nettype none

module lzd_outbuf (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                load,
    input  wire lzd_pkg::result_t                    res,
    output      logic                                free,
    output      logic                                m_valid,
    input  wire logic                                m_ready,
    output      logic [lzd_pkg::OUT_BYTES_W-1:0]     m_out_bytes,
    output      logic [lzd_pkg::OUT_COUNT_W-1:0]     m_out_count,
    output      logic                                m_run_last,
    output      logic                                m_format_error
);
    import lzd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    // slot free when empty or being taken this cycle
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= res;
        end
    end

    assign m_valid        = valid_reg;
    assign m_out_bytes    = word_reg.out_bytes;
    assign m_out_count    = word_reg.out_count;
    assign m_run_last     = word_reg.run_last;
    assign m_format_error = word_reg.format_error;

endmodule

`default_nettype wire

@@ sv/lzd_ctrl.sv @@
// token parser and history copy sequencer of the lz77 decompressor
// depends on lzd_pkg; drives the history ram and the output register
`default_nettype none
`include "lz77_token_decompressor_defines.svh"

module lzd_ctrl #(
    parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire logic [lzd_pkg::BYTE_W-1:0]       s_compressed_byte,
    input  wire logic                             s_block_last,
    input  wire logic                             out_free,
    output      logic                             res_load,
    output      lzd_pkg::result_t                 res,
    output      logic                             ram_we,
    output      logic [$clog2(HISTORY_DEPTH)-1:0] ram_waddr,
    output      logic [lzd_pkg::BYTE_W-1:0]       ram_wdata,
    output      logic                             ram_re,
    output      logic [$clog2(HISTORY_DEPTH)-1:0] ram_raddr,
    input  wire logic [lzd_pkg::BYTE_W-1:0]       ram_rdata
);
    import lzd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;

    logic [LIT_LEFT_W-1:0] literal_left_reg, literal_left_next;
    logic [OFF_HIGH_W-1:0] offset_high_reg, offset_high_next;
    logic [BYTE_W-1:0]     offset_low_reg, offset_low_next;
    logic [LEN_CODE_W-1:0] length_code_reg, length_code_next;
    logic [AW-1:0]         wp_reg, wp_next;
    logic [PRODUCED_W-1:0] produced_reg, produced_next;
    logic [AW-1:0]         src_reg, src_next;
    logic [COPY_LEN_W-1:0] left_reg, left_next;
    logic [SLOT_W-1:0]     cnt_reg, cnt_next;
    logic [BYTES_PER_RESULT-1:0][BYTE_W-1:0] acc_reg, acc_next;
    logic                  dist_one_reg, dist_one_next;
    logic                  first_reg, first_next;
    logic [BYTE_W-1:0]     prev_byte_reg, prev_byte_next;
    logic                  clear_pending_reg, clear_pending_next;

    logic                  in_fire;
    logic [BYTE_W-1:0]     off_low_sel;
    logic [PRODUCED_W-1:0] copy_dist;
    logic                  too_far;
    logic [AW:0]           src_diff;
    logic [AW-1:0]         src0;
    logic [AW-1:0]         src_inc;
    logic [AW-1:0]         wp_inc;
    logic [PRODUCED_W-1:0] produced_inc;
    logic                  copy_start;
    logic [COPY_LEN_W-1:0] copy_len;
    logic                  trunc;
    logic [LIT_LEFT_W-1:0] lit_after;
    logic [BYTE_W-1:0]     copy_byte;
    logic                  copy_emit;
    logic                  copy_adv;
    logic [BYTES_PER_RESULT-1:0][BYTE_W-1:0] acc_fill;

    assign in_fire = s_valid && s_ready;

    // copy distance and first source address
    assign off_low_sel = (phase_reg == PH_OFFSET) ? s_compressed_byte : offset_low_reg;
    assign copy_dist   = {1'b0, offset_high_reg, off_low_sel} + PRODUCED_W'(1);
    assign too_far     = copy_dist > produced_reg;

    always_comb begin
        src_diff = {1'b0, wp_reg} - (AW+1)'(copy_dist);
        if ({1'b0, wp_reg} < (AW+1)'(copy_dist)) begin
            src_diff = src_diff + DEPTH_W;
        end
    end
    assign src0 = src_diff[AW-1:0];

    // circular pointer steps and saturating count
    assign src_inc      = (src_reg == LAST_ADDR) ? '0 : src_reg + AW'(1);
    assign wp_inc       = (wp_reg == LAST_ADDR) ? '0 : wp_reg + AW'(1);
    assign produced_inc = (produced_reg == PRODUCED_MAX) ? produced_reg
                                                         : produced_reg + PRODUCED_W'(1);

    // byte being copied: distance one reads the byte pushed just before
    assign copy_byte = (dist_one_reg && !first_reg) ? prev_byte_reg : ram_rdata;
    assign copy_emit = (cnt_reg == SLOT_W'(BYTES_PER_RESULT - 1)) ||
                       (left_reg == COPY_LEN_W'(1));
    assign copy_adv  = !copy_emit || out_free;

    always_comb begin
        acc_fill          = acc_reg;
        acc_fill[cnt_reg] = copy_byte;
    end

    assign lit_after = (literal_left_reg != '0) ? literal_left_reg - LIT_LEFT_W'(1) : '0;
    assign copy_len  = (phase_reg == PH_LENGTH)
                     ? LONG_COPY_BASE + COPY_LEN_W'(s_compressed_byte)
                     : SHORT_COPY_BASE + COPY_LEN_W'(length_code_reg);

    // does the accepted word open a copy
    always_comb begin
        copy_start = 1'b0;
        if (in_fire && !too_far) begin
            if (phase_reg == PH_LENGTH) begin
                copy_start = 1'b1;
            end else if (phase_reg == PH_OFFSET && length_code_reg != LEN_CODE_LONG) begin
                copy_start = 1'b1;
            end
        end
    end

    assign trunc = s_block_last && (lit_after != '0);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (copy_start) begin
                    state_next = ST_COPY;
                end else if (in_fire && phase_reg == PH_LITERAL && trunc) begin
                    state_next = ST_ERR;
                end
            end
            ST_COPY: begin
                if (copy_adv && left_reg == COPY_LEN_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake output
    always_comb begin
        case (state_reg)
            ST_IDLE: s_ready = out_free;
            default: s_ready = 1'b0;
        endcase
    end

    // parser, history access and result words
    always_comb begin
        phase_next         = phase_reg;
        literal_left_next  = literal_left_reg;
        offset_high_next   = offset_high_reg;
        offset_low_next    = offset_low_reg;
        length_code_next   = length_code_reg;
        wp_next            = wp_reg;
        produced_next      = produced_reg;
        src_next           = src_reg;
        left_next          = left_reg;
        cnt_next           = cnt_reg;
        acc_next           = acc_reg;
        dist_one_next      = dist_one_reg;
        first_next         = first_reg;
        prev_byte_next     = prev_byte_reg;
        clear_pending_next = clear_pending_reg;
        res_load           = 1'b0;
        res                = err_result();
        ram_we             = 1'b0;
        ram_waddr          = wp_reg;
        ram_wdata          = s_compressed_byte;
        ram_re             = 1'b0;
        ram_raddr          = src0;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (phase_reg)
                        PH_HEADER: begin
                            length_code_next = s_compressed_byte[7:5];
                            if (s_compressed_byte[7:5] == LEN_CODE_LITERAL) begin
                                literal_left_next = {1'b0, s_compressed_byte[4:0]}
                                                  + LIT_LEFT_W'(1);
                                phase_next = PH_LITERAL;
                            end else begin
                                offset_high_next = s_compressed_byte[4:0];
                                phase_next       = PH_OFFSET;
                            end
                            // header cut off by block end
                            if (s_block_last) begin
                                res_load = 1'b1;
                                res      = err_result();
                            end
                        end
                        PH_LITERAL: begin
                            ram_we            = 1'b1;
                            wp_next           = wp_inc;
                            produced_next     = produced_inc;
                            literal_left_next = lit_after;
                            if (lit_after == '0) begin
                                phase_next = PH_HEADER;
                            end
                            res_load = 1'b1;
                            res      = literal_result(s_compressed_byte, !trunc);
                        end
                        PH_OFFSET: begin
                            offset_low_next = s_compressed_byte;
                            if (length_code_reg == LEN_CODE_LONG) begin
                                phase_next = PH_LENGTH;
                                if (s_block_last) begin
                                    res_load = 1'b1;
                                    res      = err_result();
                                end
                            end else begin
                                phase_next = PH_HEADER;
                                if (too_far) begin
                                    res_load = 1'b1;
                                    res      = err_result();
                                end
                            end
                        end
                        PH_LENGTH: begin
                            phase_next = PH_HEADER;
                            if (too_far) begin
                                res_load = 1'b1;
                                res      = err_result();
                            end
                        end
                        default: phase_next = PH_HEADER;
                    endcase

                    // arm the copy and fetch its first byte
                    if (copy_start) begin
                        ram_re             = 1'b1;
                        ram_raddr          = src0;
                        src_next           = src0;
                        left_next          = copy_len;
                        cnt_next           = '0;
                        acc_next           = '0;
                        first_next         = 1'b1;
                        dist_one_next      = (copy_dist == PRODUCED_W'(1));
                        clear_pending_next = s_block_last;
                    end

                    // block end: parser and count back to start
                    if (s_block_last) begin
                        phase_next        = PH_HEADER;
                        literal_left_next = '0;
                        if (!copy_start) begin
                            produced_next = '0;
                        end
                    end
                end
            end
            ST_COPY: begin
                if (copy_adv) begin
                    ram_we         = 1'b1;
                    ram_wdata      = copy_byte;
                    wp_next        = wp_inc;
                    produced_next  = produced_inc;
                    prev_byte_next = copy_byte;
                    first_next     = 1'b0;
                    left_next      = left_reg - COPY_LEN_W'(1);
                    if (copy_emit) begin
                        res_load           = 1'b1;
                        res.out_bytes      = acc_fill;
                        res.out_count      = {1'b0, cnt_reg} + OUT_COUNT_W'(1);
                        res.run_last       = (left_reg == COPY_LEN_W'(1));
                        res.format_error   = 1'b0;
                        acc_next           = '0;
                        cnt_next           = '0;
                    end else begin
                        acc_next = acc_fill;
                        cnt_next = cnt_reg + SLOT_W'(1);
                    end
                    if (left_reg != COPY_LEN_W'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = src_inc;
                        src_next  = src_inc;
                    end else if (clear_pending_reg) begin
                        produced_next = '0;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    res_load = 1'b1;
                    res      = err_result();
                end
            end
            default: begin
                res_load = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            phase_reg         <= PH_HEADER;
            literal_left_reg  <= '0;
            offset_high_reg   <= '0;
            offset_low_reg    <= '0;
            length_code_reg   <= '0;
            wp_reg            <= '0;
            produced_reg      <= '0;
            left_reg          <= '0;
            cnt_reg           <= '0;
            first_reg         <= 1'b0;
            dist_one_reg      <= 1'b0;
            clear_pending_reg <= 1'b0;
        end else begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            literal_left_reg  <= literal_left_next;
            offset_high_reg   <= offset_high_next;
            offset_low_reg    <= offset_low_next;
            length_code_reg   <= length_code_next;
            wp_reg            <= wp_next;
            produced_reg      <= produced_next;
            left_reg          <= left_next;
            cnt_reg           <= cnt_next;
            first_reg         <= first_next;
            dist_one_reg      <= dist_one_next;
            clear_pending_reg <= clear_pending_next;
        end
    end

    // copy datapath, no reset
    always_ff @(posedge aclk) begin
        src_reg       <= src_next;
        acc_reg       <= acc_next;
        prev_byte_reg <= prev_byte_next;
    end

    `LZD_ASSERT(a_load_when_free, res_load |-> out_free, "result word loaded into a busy slot")
    `LZD_ASSERT(a_copy_has_bytes, (state_reg == ST_COPY) |-> (left_reg != '0), "copy with no bytes left")
    `LZD_ASSERT(a_err_word_shape, (res_load && res.format_error) |-> (res.out_count == '0 && res.run_last), "malformed error word")
    `LZD_ASSERT(a_produced_sat, produced_reg <= PRODUCED_MAX, "produced count beyond saturation")

endmodule

`default_nettype wire

@@ sv/lz77_token_decompressor.sv @@
// Decodes a byte stream of lz77 tokens (literal runs, short and long copies) into result words of
// up to eight bytes. One compressed byte is taken per cycle while no copy or error word is
// pending and the output register is free; a literal cut short by block end is followed by the
// error word. A copy takes no input, as the 8-bit history ram gives one byte per cycle through
// its single read port; distance-one copies are served by forwarding the byte just written.
// The history is not cleared after reset and needs no clearing pass: reads never reach past
// the bytes produced in the current block.
// depends on lzd_pkg, lzd_ram, lzd_outbuf and lzd_ctrl
`default_nettype none

module lz77_token_decompressor #(
    parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output      logic                            s_ready,
    input  wire logic [lzd_pkg::BYTE_W-1:0]      s_compressed_byte,
    input  wire logic                            s_block_last,
    output      logic                            m_valid,
    input  wire logic                            m_ready,
    output      logic [lzd_pkg::OUT_BYTES_W-1:0] m_out_bytes,
    output      logic [lzd_pkg::OUT_COUNT_W-1:0] m_out_count,
    output      logic                            m_run_last,
    output      logic                            m_format_error
);
    import lzd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    logic              out_free;
    logic              res_load;
    result_t           res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // history of decoded bytes
    lzd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // parser and copy sequencer
    lzd_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_compressed_byte (s_compressed_byte),
        .s_block_last      (s_block_last),
        .out_free          (out_free),
        .res_load          (res_load),
        .res               (res),
        .ram_we            (ram_we),
        .ram_waddr         (ram_waddr),
        .ram_wdata         (ram_wdata),
        .ram_re            (ram_re),
        .ram_raddr         (ram_raddr),
        .ram_rdata         (ram_rdata)
    );

    // result word register
    lzd_outbuf u_outbuf (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (res_load),
        .res            (res),
        .free           (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_bytes    (m_out_bytes),
        .m_out_count    (m_out_count),
        .m_run_last     (m_run_last),
        .m_format_error (m_format_error)
    );

endmodule

`default_nettype wire

@@ bench/tb_lz77_token_decompressor.sv @@
`timescale 1ns / 100ps
// self-checking bench for lz77_token_decompressor: directed table, then random token streams
// an in-bench decoder predicts every result word; depends on lzd_pkg and the block's rtl

module tb_lz77_token_decompressor;
    import lzd_pkg::*;

    localparam int HIST_DEPTH   = HISTORY_DEPTH_DEF;
    localparam int HIST_AW      = $clog2(HIST_DEPTH);
    localparam int RANDOM_ITEMS = 40;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 1_500_000;

    typedef struct {
        logic [BYTE_W-1:0] code;
        logic              last;
        bit                pinned;
        result_t           word;
    } stim_row_t;

    // block ports
    logic                   aclk              = 1'b0;
    logic                   aresetn           = 1'b0;
    logic                   s_valid           = 1'b0;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_compressed_byte = '0;
    logic                   s_block_last      = 1'b0;
    logic                   m_valid;
    logic                   m_ready           = 1'b0;
    logic [OUT_BYTES_W-1:0] m_out_bytes;
    logic [OUT_COUNT_W-1:0] m_out_count;
    logic                   m_run_last;
    logic                   m_format_error;

    // decoder state mirrored by the bench
    logic [BYTE_W-1:0]     hist [HIST_DEPTH];
    logic [HIST_AW-1:0]    wr_pos   = '0;
    logic [PRODUCED_W-1:0] produced = '0;
    phase_t                phase    = PH_HEADER;
    logic [LIT_LEFT_W-1:0] lit_left = '0;
    logic [OFF_HIGH_W-1:0] off_hi   = '0;
    logic [BYTE_W-1:0]     off_lo   = '0;
    logic [LEN_CODE_W-1:0] len_code = '0;
    result_t               words_due [$];

    // sender and receiver bookkeeping
    int      burst_left  = 4;
    int      items_sent  = 0;
    int      rx_hold     = 0;
    int      fail_count  = 0;
    int      cycle_count = 0;
    bit      cur_pinned  = 1'b0;
    result_t cur_pin_word = '0;

    lz77_token_decompressor i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_compressed_byte (s_compressed_byte),
        .s_block_last      (s_block_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_bytes       (m_out_bytes),
        .m_out_count       (m_out_count),
        .m_run_last        (m_run_last),
        .m_format_error    (m_format_error)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic result_t make_word(input logic [OUT_BYTES_W-1:0] bytes, input int count,
                                          input logic last, input logic err);
        result_t w;
        w.out_bytes    = bytes;
        w.out_count    = OUT_COUNT_W'(count);
        w.run_last     = last;
        w.format_error = err;
        return w;
    endfunction

    function automatic void append_history(input logic [BYTE_W-1:0] b);
        hist[wr_pos] = b;
        wr_pos = wr_pos + 1'b1;
        if (produced < PRODUCED_MAX)
            produced = produced + 1'b1;
    endfunction

    // byte-by-byte copy so that overlapping matches repeat their pattern
    function automatic void copy_match(input int length);
        int                 distance;
        int                 fill;
        int                 i;
        logic [HIST_AW-1:0] src;
        logic [BYTE_W-1:0]  b;
        result_t            w;
        distance = int'(off_hi) * 256 + int'(off_lo) + 1;
        if (distance > int'(produced)) begin
            words_due.push_back(make_word('0, 0, 1'b1, 1'b1));
            return;
        end
        w = make_word('0, 0, 1'b0, 1'b0);
        fill = 0;
        for (i = 0; i < length; i++) begin
            src = wr_pos - HIST_AW'(distance);
            b = hist[src];
            append_history(b);
            w.out_bytes[8*fill +: 8] = b;
            fill++;
            if (fill == BYTES_PER_RESULT || i == length - 1) begin
                w.out_count = OUT_COUNT_W'(fill);
                w.run_last = (i == length - 1);
                words_due.push_back(w);
                w = make_word('0, 0, 1'b0, 1'b0);
                fill = 0;
            end
        end
    endfunction

    // token parser: queues the words that one compressed byte gives
    function automatic void decode_byte(input logic [BYTE_W-1:0] code, input logic last);
        logic cut;
        cut = 1'b0;
        case (phase)
            PH_HEADER: begin
                len_code = code[7:5];
                if (len_code == LEN_CODE_LITERAL) begin
                    lit_left = LIT_LEFT_W'(code[4:0]) + 1'b1;
                    phase = PH_LITERAL;
                end else begin
                    off_hi = code[4:0];
                    phase = PH_OFFSET;
                end
                cut = last;
            end
            PH_LITERAL: begin
                append_history(code);
                if (lit_left != 0)
                    lit_left = lit_left - 1'b1;
                if (lit_left == 0)
                    phase = PH_HEADER;
                cut = last && (lit_left != 0);
                words_due.push_back(make_word(OUT_BYTES_W'(code), 1, !cut, 1'b0));
            end
            PH_OFFSET: begin
                off_lo = code;
                if (len_code == LEN_CODE_LONG) begin
                    phase = PH_LENGTH;
                    cut = last;
                end else begin
                    phase = PH_HEADER;
                    copy_match(int'(SHORT_COPY_BASE) + int'(len_code));
                end
            end
            default: begin
                phase = PH_HEADER;
                copy_match(int'(LONG_COPY_BASE) + int'(code));
            end
        endcase
        // truncated token
        if (cut)
            words_due.push_back(make_word('0, 0, 1'b1, 1'b1));
        // block end clears the parser and the produced count
        if (last) begin
            phase = PH_HEADER;
            produced = '0;
            lit_left = '0;
        end
    endfunction

    // copy distance: mostly within the block so far, sometimes anywhere
    function automatic int pick_distance();
        int avail;
        avail = int'(produced);
        if (avail == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(1, HIST_DEPTH);
        if ($urandom_range(0, 1) == 1)
            return $urandom_range(1, (avail < 8) ? avail : 8);
        return $urandom_range(1, avail);
    endfunction

    // random short-copy length code
    function automatic logic [LEN_CODE_W-1:0] pick_short_code();
        return LEN_CODE_W'($urandom_range(1, 6));
    endfunction

    // one input word, then a gap when the current burst runs out
    task automatic send_item(input logic [BYTE_W-1:0] code, input logic last, input bit pinned,
                             input result_t word);
        s_valid           <= 1'b1;
        s_compressed_byte <= code;
        s_block_last      <= last;
        cur_pinned   = pinned;
        cur_pin_word = word;
        do @(posedge aclk); while (s_ready !== 1'b1);
        items_sent++;
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3))
                @(negedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
    endtask

    // cut_on: 1 ends the block on the header, 2 on the offset byte, 3 on the length byte
    task automatic send_copy(input logic [LEN_CODE_W-1:0] code, input int distance,
                             input logic [BYTE_W-1:0] len_byte, input int cut_on);
        logic [HIST_AW-1:0] d;
        d = HIST_AW'(distance - 1);
        send_item({code, d[HIST_AW-1 -: OFF_HIGH_W]}, cut_on == 1, 1'b0, '0);
        if (cut_on == 1)
            return;
        send_item(d[7:0], cut_on == 2, 1'b0, '0);
        if (cut_on == 2 || code != LEN_CODE_LONG)
            return;
        send_item(len_byte, cut_on == 3, 1'b0, '0);
    endtask

    // cut_at: 0 ends the block on the header, k on the k-th literal, otherwise no block end
    task automatic send_literals(input int length, input int cut_at);
        int i;
        send_item({LEN_CODE_LITERAL, OFF_HIGH_W'(length - 1)}, cut_at == 0, 1'b0, '0);
        if (cut_at == 0)
            return;
        for (i = 1; i <= length; i++) begin
            send_item(8'($urandom), cut_at == i, 1'b0, '0);
            if (cut_at == i)
                return;
        end
    endtask

    // hold the sender until every predicted word has come out
    task automatic drain_words();
        s_valid <= 1'b0;
        do @(negedge aclk); while (words_due.size() != 0);
    endtask

    // receiver stall pattern: short stalls, occasional long ones, long stall-free stretches
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            m_ready <= !m_ready;
            if (m_ready)
                rx_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12)
                                                       : $urandom_range(0, 2);
            else
                rx_hold = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(0, 5);
        end
    end

    // prediction on each accepted input word, comparison on each accepted result word
    always @(posedge aclk) begin : scoreboard
        int      base;
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                base = words_due.size();
                decode_byte(s_compressed_byte, s_block_last);
                if (cur_pinned) begin
                    if (words_due.size() != base + 1) begin
                        $error("word count for pinned row: expected 1, actual %0d",
                               words_due.size() - base);
                        fail_count++;
                    end else begin
                        words_due[base] = cur_pin_word;
                    end
                end
            end
            if (m_valid && m_ready) begin
                if (words_due.size() == 0) begin
                    $error("unexpected result word: out_bytes %h out_count %0d",
                           m_out_bytes, m_out_count);
                    fail_count++;
                end else begin
                    want = words_due.pop_front();
                    if (m_out_bytes !== want.out_bytes) begin
                        $error("out_bytes: expected %h, actual %h", want.out_bytes, m_out_bytes);
                        fail_count++;
                    end
                    if (m_out_count !== want.out_count) begin
                        $error("out_count: expected %0d, actual %0d",
                               want.out_count, m_out_count);
                        fail_count++;
                    end
                    if (m_run_last !== want.run_last) begin
                        $error("run_last: expected %b, actual %b", want.run_last, m_run_last);
                        fail_count++;
                    end
                    if (m_format_error !== want.format_error) begin
                        $error("format_error: expected %b, actual %b",
                               want.format_error, m_format_error);
                        fail_count++;
                    end
                end
            end
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        stim_row_t         rows [$];
        result_t           err_word;
        int                i;
        int                base_count;
        int                r;
        int                length;
        int                cut;
        logic [BYTE_W-1:0] len_byte;

        err_word = make_word('0, 0, 1'b1, 1'b1);
        // copy reaching back before the first byte of the block
        rows.push_back('{8'h20, 1'b0, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, 1'b1, err_word});
        // literal run with extreme byte values
        rows.push_back('{8'h02, 1'b0, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, 1'b1, make_word(64'h00, 1, 1'b1, 1'b0)});
        rows.push_back('{8'hFF, 1'b0, 1'b1, make_word(64'hFF, 1, 1'b1, 1'b0)});
        rows.push_back('{8'h5A, 1'b0, 1'b1, make_word(64'h5A, 1, 1'b1, 1'b0)});
        // longest short copy at distance one
        rows.push_back('{8'hC0, 1'b0, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, 1'b1, make_word(64'h5A5A5A5A5A5A5A5A, 8, 1'b1, 1'b0)});
        // longest long copy, overlapping
        rows.push_back('{8'hE0, 1'b0, 1'b0, '0});
        rows.push_back('{8'h02, 1'b0, 1'b0, '0});
        rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
        // largest offset, beyond the bytes produced
        rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
        rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, 1'b1, err_word});
        // literal run cut short by block end
        rows.push_back('{8'h01, 1'b0, 1'b0, '0});
        rows.push_back('{8'h11, 1'b1, 1'b0, '0});
        // block end on headers and on a long-copy offset byte
        rows.push_back('{8'h05, 1'b1, 1'b1, err_word});
        rows.push_back('{8'hE0, 1'b1, 1'b1, err_word});
        rows.push_back('{8'hE0, 1'b0, 1'b0, '0});
        rows.push_back('{8'h00, 1'b1, 1'b1, err_word});
        // shortest long copy ending the block
        rows.push_back('{8'h00, 1'b0, 1'b0, '0});
        rows.push_back('{8'h42, 1'b0, 1'b1, make_word(64'h42, 1, 1'b1, 1'b0)});
        rows.push_back('{8'hE0, 1'b0, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, 1'b0, '0});
        rows.push_back('{8'h00, 1'b1, 1'b0, '0});

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < rows.size(); i++)
            send_item(rows[i].code, rows[i].last, rows[i].pinned, rows[i].word);
        drain_words();

        // one long block: saturate the produced count, wrap the history, copy from the far end
        send_literals(1, -1);
        while (produced < PRODUCED_MAX)
            send_copy(LEN_CODE_LONG, $urandom_range(1, int'(produced)), 8'hFF, 0);
        send_copy(pick_short_code(), HIST_DEPTH, 8'h00, 0);
        send_copy(LEN_CODE_LONG, HIST_DEPTH, 8'($urandom), 0);
        send_copy(LEN_CODE_LONG, pick_distance(), 8'($urandom_range(0, 15)), 3);

        // random token streams with some noise and broken tokens
        base_count = items_sent;
        while (items_sent - base_count < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_item(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, '0);
            end else if (r < 42) begin
                length = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32)
                                                     : $urandom_range(1, 6);
                cut = $urandom_range(0, 11);
                send_literals(length, (cut == 0) ? $urandom_range(0, length)
                                                 : ((cut == 1) ? length : -1));
            end else if (r < 75) begin
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
                send_copy(LEN_CODE_W'($urandom_range(1, 6)), pick_distance(), 8'h00, cut);
            end else begin
                len_byte = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 15));
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
                send_copy(LEN_CODE_LONG, pick_distance(), len_byte, cut);
            end
            if ($urandom_range(0, 24) == 0)
                drain_words();
        end

        drain_words();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
